// ===== src/pts_pkg.sv =====
// Package for the priority task scheduler: request/response words, slot record,
// sequencer states, operation and status codes, priority clamp. No dependencies.
package pts_pkg;

  localparam int MaxTasks   = 64;
  localparam int NumLevels  = 40;
  localparam int IdW        = 6;
  localparam int LvlW       = 6;
  localparam int CntW       = 7;

  localparam logic [2:0] OpCreate    = 3'd0;
  localparam logic [2:0] OpSchedule  = 3'd1;
  localparam logic [2:0] OpTerminate = 3'd2;
  localparam logic [2:0] OpSetPrio   = 3'd3;
  localparam logic [2:0] OpGetPrio   = 3'd4;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSlot  = 2'd1;
  localparam logic [1:0] StBadId   = 2'd2;
  localparam logic [1:0] StNoReady = 2'd3;

  localparam logic [IdW-1:0]  LastSlot  = IdW'(MaxTasks - 1);
  localparam logic [LvlW-1:0] LastLevel = LvlW'(NumLevels - 1);

  typedef struct packed {
    logic [2:0]        mode;
    logic [5:0]        task_id;
    logic signed [7:0] priority_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [5:0]        result_id;
    logic signed [7:0] priority_read;
    logic [6:0]        active_count;
    logic [31:0]       switch_count;
  } rsp_t;

  typedef struct packed {
    logic [7:0]      prio;
    logic [LvlW-1:0] lvl;
    logic [IdW-1:0]  nxt;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_C_SCAN, S_C_PUSH, S_Q_SCAN, S_Q_RD, S_Q_POP,
    S_T_RD, S_T_LVL, S_T_HEAD, S_T_WALK, S_T_FREE,
    S_P_RD, S_P_DO, S_OUT
  } state_t;

  // Clamp a signed priority to a queue level
  function automatic logic [LvlW-1:0] clamp_level(logic signed [7:0] p);
    logic [LvlW-1:0] r;
    if (p < 0) r = '0;
    else if (p > 8'(signed'(NumLevels - 1))) r = LastLevel;
    else r = LvlW'(p);
    return r;
  endfunction

endpackage

// ===== src/priority_task_scheduler_unit.sv =====
// Priority task scheduler top level: slot record memory, level head memory
// and the sequencer that walks them. Depends on pts_pkg.
//
//  channel | signals                 | direction | word
//  request | req_valid/req_ready/req | in        | pts_pkg::req_t
//  result  | rsp_valid/rsp_ready/rsp | out       | pts_pkg::rsp_t
//
// One request at a time. Create scans slot flags, one slot a cycle. Schedule
// scans level heads through the head memory read port, one level a cycle.
// Terminate follows a level list, one link a cycle through the slot memory
// read port. Reset clears all flags at once; no clearing pass. A stalled
// result holds in the output register; the next request is taken once the
// sequencer is idle.
module priority_task_scheduler_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  pts_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output pts_pkg::rsp_t   rsp
);

  localparam int IdW  = pts_pkg::IdW;
  localparam int LvlW = pts_pkg::LvlW;

  pts_pkg::state_t state, state_next;
  pts_pkg::req_t   cur, cur_next;
  logic [IdW-1:0]  cnt, cnt_next;
  logic            pend, pend_next;
  logic [IdW-1:0]  tid, tid_next;
  logic [LvlW-1:0] lvl, lvl_next;
  logic [IdW-1:0]  tnext, tnext_next;
  logic [IdW-1:0]  prev, prev_next;
  logic [1:0]      res_status, res_status_next;
  logic [IdW-1:0]  res_rid, res_rid_next;
  logic [7:0]      res_pread, res_pread_next;
  logic [pts_pkg::CntW-1:0] used_cnt, used_cnt_next;
  logic [31:0]     switches, switches_next;
  logic [pts_pkg::MaxTasks-1:0] used, used_next;
  logic [pts_pkg::MaxTasks-1:0] queued, queued_next;
  logic [pts_pkg::NumLevels-1:0] head_vld;

  // slot record memory
  pts_pkg::slot_t  slot_mem [pts_pkg::MaxTasks];
  pts_pkg::slot_t  sm_rdata, sm_wdata;
  logic [IdW-1:0]  sm_raddr, sm_waddr;
  logic            sm_we;

  // level head memory
  logic [IdW-1:0]  head_mem [pts_pkg::NumLevels];
  logic [IdW-1:0]  hm_rdata, hm_wdata;
  logic [LvlW-1:0] hm_raddr, hm_waddr, hm_ra_q;
  logic            hm_we;
  logic [IdW-1:0]  hd;

  logic            take;
  logic            id_ok;

  assign req_ready = (state == pts_pkg::S_IDLE);
  assign take      = req_valid && req_ready;
  assign id_ok     = (req.task_id != '0) && used[req.task_id];
  assign hd        = head_vld[hm_ra_q] ? hm_rdata : '0;

  // memories: one write and one registered read a cycle each
  always_ff @(posedge clk) begin
    if (sm_we) slot_mem[sm_waddr] <= sm_wdata;
    sm_rdata <= slot_mem[sm_raddr];
    if (hm_we) head_mem[hm_waddr] <= hm_wdata;
    hm_rdata <= head_mem[hm_raddr];
    hm_ra_q  <= hm_raddr;
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pts_pkg::S_IDLE;
      used      <= '0;
      queued    <= '0;
      head_vld  <= '0;
      used_cnt  <= '0;
      switches  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      queued   <= queued_next;
      used_cnt <= used_cnt_next;
      switches <= switches_next;
      if (hm_we) head_vld[hm_waddr] <= 1'b1;
      if (state == pts_pkg::S_OUT && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    cnt        <= cnt_next;
    pend       <= pend_next;
    tid        <= tid_next;
    lvl        <= lvl_next;
    tnext      <= tnext_next;
    prev       <= prev_next;
    res_status <= res_status_next;
    res_rid    <= res_rid_next;
    res_pread  <= res_pread_next;
    if (state == pts_pkg::S_OUT && (!rsp_valid || rsp_ready)) begin
      rsp.status        <= res_status;
      rsp.result_id     <= res_rid;
      rsp.priority_read <= res_pread;
      rsp.active_count  <= used_cnt;
      rsp.switch_count  <= switches;
    end
  end

  // sequencer: next state, memory accesses and result
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    cnt_next        = cnt;
    pend_next       = pend;
    tid_next        = tid;
    lvl_next        = lvl;
    tnext_next      = tnext;
    prev_next       = prev;
    res_status_next = res_status;
    res_rid_next    = res_rid;
    res_pread_next  = res_pread;
    used_cnt_next   = used_cnt;
    switches_next   = switches;
    used_next       = used;
    queued_next     = queued;
    sm_raddr        = tid;
    sm_we           = 1'b0;
    sm_waddr        = tid;
    sm_wdata        = sm_rdata;
    hm_raddr        = lvl;
    hm_we           = 1'b0;
    hm_waddr        = lvl;
    hm_wdata        = '0;

    case (state)
      pts_pkg::S_IDLE: begin
        if (take) begin
          cur_next        = req;
          tid_next        = req.task_id;
          res_status_next = pts_pkg::StOk;
          res_rid_next    = '0;
          res_pread_next  = '0;
          pend_next       = 1'b0;
          case (req.mode)
            pts_pkg::OpCreate: begin
              cnt_next   = IdW'(1);
              state_next = pts_pkg::S_C_SCAN;
            end
            pts_pkg::OpSchedule: begin
              cnt_next   = '0;
              state_next = pts_pkg::S_Q_SCAN;
            end
            pts_pkg::OpTerminate: begin
              if (!id_ok) begin
                res_status_next = pts_pkg::StBadId;
                state_next      = pts_pkg::S_OUT;
              end else if (queued[req.task_id]) begin
                state_next = pts_pkg::S_T_RD;
              end else begin
                state_next = pts_pkg::S_T_FREE;
              end
            end
            pts_pkg::OpSetPrio, pts_pkg::OpGetPrio: begin
              if (!id_ok) begin
                res_status_next = pts_pkg::StBadId;
                state_next      = pts_pkg::S_OUT;
              end else begin
                state_next = pts_pkg::S_P_RD;
              end
            end
            default: begin
              res_status_next = pts_pkg::StBadId;
              state_next      = pts_pkg::S_OUT;
            end
          endcase
        end
      end

      // find the lowest free slot above slot 0
      pts_pkg::S_C_SCAN: begin
        if (!used[cnt]) begin
          tid_next   = cnt;
          lvl_next   = pts_pkg::clamp_level(cur.priority_value);
          hm_raddr   = pts_pkg::clamp_level(cur.priority_value);
          state_next = pts_pkg::S_C_PUSH;
        end else if (cnt == pts_pkg::LastSlot) begin
          res_status_next = pts_pkg::StNoSlot;
          state_next      = pts_pkg::S_OUT;
        end else begin
          cnt_next = cnt + IdW'(1);
        end
      end

      // push the new slot on its level
      pts_pkg::S_C_PUSH: begin
        sm_we            = 1'b1;
        sm_waddr         = tid;
        sm_wdata.prio    = cur.priority_value;
        sm_wdata.lvl     = lvl;
        sm_wdata.nxt     = hd;
        hm_we            = 1'b1;
        hm_waddr         = lvl;
        hm_wdata         = tid;
        used_next[tid]   = 1'b1;
        queued_next[tid] = 1'b1;
        used_cnt_next    = used_cnt + pts_pkg::CntW'(1);
        res_rid_next     = tid;
        state_next       = pts_pkg::S_OUT;
      end

      // pipelined head scan: issue one level, check the one before
      pts_pkg::S_Q_SCAN: begin
        hm_raddr  = cnt;
        pend_next = 1'b1;
        if (cnt != pts_pkg::LastLevel) cnt_next = cnt + LvlW'(1);
        if (pend) begin
          if (hd != '0) begin
            tid_next   = hd;
            lvl_next   = hm_ra_q;
            state_next = pts_pkg::S_Q_RD;
          end else if (hm_ra_q == pts_pkg::LastLevel) begin
            res_status_next = pts_pkg::StNoReady;
            state_next      = pts_pkg::S_OUT;
          end
        end
      end

      pts_pkg::S_Q_RD: begin
        sm_raddr   = tid;
        state_next = pts_pkg::S_Q_POP;
      end

      // pop the head and count a switch
      pts_pkg::S_Q_POP: begin
        hm_we            = 1'b1;
        hm_waddr         = lvl;
        hm_wdata         = sm_rdata.nxt;
        queued_next[tid] = 1'b0;
        switches_next    = switches + 32'd1;
        res_rid_next     = tid;
        state_next       = pts_pkg::S_OUT;
      end

      pts_pkg::S_T_RD: begin
        sm_raddr   = tid;
        state_next = pts_pkg::S_T_LVL;
      end

      pts_pkg::S_T_LVL: begin
        lvl_next   = sm_rdata.lvl;
        tnext_next = sm_rdata.nxt;
        hm_raddr   = sm_rdata.lvl;
        state_next = pts_pkg::S_T_HEAD;
      end

      pts_pkg::S_T_HEAD: begin
        if (hd == tid) begin
          hm_we      = 1'b1;
          hm_waddr   = lvl;
          hm_wdata   = tnext;
          state_next = pts_pkg::S_T_FREE;
        end else if (hd == '0) begin
          state_next = pts_pkg::S_T_FREE;
        end else begin
          prev_next  = hd;
          sm_raddr   = hd;
          state_next = pts_pkg::S_T_WALK;
        end
      end

      // follow the list until the link to the target or the end of the list
      pts_pkg::S_T_WALK: begin
        if (sm_rdata.nxt == tid) begin
          sm_we        = 1'b1;
          sm_waddr     = prev;
          sm_wdata     = sm_rdata;
          sm_wdata.nxt = tnext;
          state_next   = pts_pkg::S_T_FREE;
        end else if (sm_rdata.nxt == '0) begin
          state_next = pts_pkg::S_T_FREE;
        end else begin
          prev_next = sm_rdata.nxt;
          sm_raddr  = sm_rdata.nxt;
        end
      end

      pts_pkg::S_T_FREE: begin
        used_next[tid]   = 1'b0;
        queued_next[tid] = 1'b0;
        used_cnt_next    = used_cnt - pts_pkg::CntW'(1);
        state_next       = pts_pkg::S_OUT;
      end

      pts_pkg::S_P_RD: begin
        sm_raddr   = tid;
        state_next = pts_pkg::S_P_DO;
      end

      pts_pkg::S_P_DO: begin
        if (cur.mode == pts_pkg::OpSetPrio) begin
          sm_we         = 1'b1;
          sm_waddr      = tid;
          sm_wdata      = sm_rdata;
          sm_wdata.prio = cur.priority_value;
        end else begin
          res_pread_next = sm_rdata.prio;
        end
        state_next = pts_pkg::S_OUT;
      end

      // hand the result to the output register
      pts_pkg::S_OUT: begin
        if (!rsp_valid || rsp_ready) state_next = pts_pkg::S_IDLE;
      end

      default: state_next = pts_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for priority_task_scheduler_unit: predicts each result
// word from a behavioural task table and compares it field by field. Depends on pts_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  pts_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  pts_pkg::rsp_t rsp;

  priority_task_scheduler_unit i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always #10 clk = ~clk;

  // Predicted task table
  logic              t_used   [pts_pkg::MaxTasks];
  logic              t_queued [pts_pkg::MaxTasks];
  logic signed [7:0] t_prio   [pts_pkg::MaxTasks];
  int                t_level  [pts_pkg::MaxTasks];
  int                t_next   [pts_pkg::MaxTasks];
  int                head     [pts_pkg::NumLevels];
  int                current_id;
  logic [31:0]       switch_total;
  int                occupied;

  pts_pkg::rsp_t expected_rsp[$];
  int   mismatches = 0;
  int   words_sent = 0;
  int   words_seen = 0;
  int   idle_cycles = 0;
  int   op_hits[8];
  bit   long_hold = 1'b0;
  bit   done = 1'b0;

  // Drop a task from the list of the level it was queued on
  function automatic void unlink_slot(int id);
    int lv, cur, prev;
    lv = t_level[id];
    prev = 0;
    cur = head[lv];
    while (cur != 0) begin
      if (cur == id) begin
        if (prev == 0) head[lv] = t_next[cur];
        else t_next[prev] = t_next[cur];
        t_next[cur] = 0;
        break;
      end
      prev = cur;
      cur = t_next[cur];
    end
    t_queued[id] = 1'b0;
  endfunction

  function automatic bit id_live(logic [5:0] id);
    return id != 0 && t_used[id];
  endfunction

  // Work out the result word for one request and advance the table
  function automatic pts_pkg::rsp_t schedule_outcome(pts_pkg::req_t r);
    pts_pkg::rsp_t o;
    int slot, lv;
    o = '0;
    o.status = pts_pkg::StOk;
    slot = 0;
    case (r.mode)
      pts_pkg::OpCreate: begin
        for (int i = 1; i < pts_pkg::MaxTasks; i++)
          if (!t_used[i]) begin slot = i; break; end
        if (slot == 0) o.status = pts_pkg::StNoSlot;
        else begin
          t_used[slot] = 1'b1;
          occupied++;
          t_prio[slot] = r.priority_value;
          lv = r.priority_value < 0 ? 0 :
               (r.priority_value > pts_pkg::NumLevels - 1 ? pts_pkg::NumLevels - 1
                                                          : r.priority_value);
          t_level[slot] = lv;
          t_next[slot] = head[lv];
          head[lv] = slot;
          t_queued[slot] = 1'b1;
          o.result_id = slot[5:0];
        end
      end
      pts_pkg::OpSchedule: begin
        for (int i = 0; i < pts_pkg::NumLevels; i++)
          if (head[i] != 0) begin slot = head[i]; break; end
        if (slot == 0) o.status = pts_pkg::StNoReady;
        else begin
          unlink_slot(slot);
          current_id = slot;
          switch_total++;
          o.result_id = slot[5:0];
        end
      end
      pts_pkg::OpTerminate: begin
        if (!id_live(r.task_id)) o.status = pts_pkg::StBadId;
        else begin
          if (t_queued[r.task_id]) unlink_slot(r.task_id);
          t_used[r.task_id] = 1'b0;
          occupied--;
        end
      end
      pts_pkg::OpSetPrio: begin
        if (!id_live(r.task_id)) o.status = pts_pkg::StBadId;
        else t_prio[r.task_id] = r.priority_value;
      end
      pts_pkg::OpGetPrio: begin
        if (!id_live(r.task_id)) o.status = pts_pkg::StBadId;
        else o.priority_read = t_prio[r.task_id];
      end
      default: o.status = pts_pkg::StBadId;
    endcase
    o.active_count = occupied[6:0];
    o.switch_count = switch_total;
    return o;
  endfunction

  // Send one word; sender bursts and gaps
  int burst_left = 0;
  task automatic send_word(logic [2:0] mode, logic [5:0] id, logic signed [7:0] prio);
    pts_pkg::req_t r;
    r.mode = mode;
    r.task_id = id;
    r.priority_value = prio;
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp.push_back(schedule_outcome(r));
    op_hits[mode]++;
    words_sent++;
    @(negedge clk);
    // end a burst with a gap
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    burst_left--;
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    @(negedge clk);
    while (expected_rsp.size() != 0) @(negedge clk);
  endtask

  // Receiver stall pattern, with one long hold-off
  initial begin
    int phase;
    phase = 0;
    @(negedge clk);
    while (!done) begin
      if (long_hold) begin
        rsp_ready <= 1'b0;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      phase++;
      if (phase % 64 < 16) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
      @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      pts_pkg::rsp_t want;
      words_seen++;
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", rsp);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status || rsp.result_id !== want.result_id ||
            rsp.priority_read !== want.priority_read ||
            rsp.active_count !== want.active_count ||
            rsp.switch_count !== want.switch_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d id=%0d pr=%0d act=%0d sw=%0d,",
                      " got st=%0d id=%0d pr=%0d act=%0d sw=%0d"},
                     want.status, want.result_id, want.priority_read, want.active_count,
                     want.switch_count, rsp.status, rsp.result_id, rsp.priority_read,
                     rsp.active_count, rsp.switch_count);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [5:0] live_or_any();
    int pick;
    pick = $urandom_range(1, pts_pkg::MaxTasks - 1);
    for (int k = 0; k < pts_pkg::MaxTasks; k++)
      if (t_used[(pick + k) % pts_pkg::MaxTasks] && (pick + k) % pts_pkg::MaxTasks != 0)
        return 6'((pick + k) % pts_pkg::MaxTasks);
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic test_directed;
    send_word(pts_pkg::OpSchedule, '0, '0);          // nothing ready
    send_word(pts_pkg::OpCreate, '0, -8'sd128);
    send_word(pts_pkg::OpCreate, '0, 8'sd127);
    send_word(pts_pkg::OpCreate, '0, 8'sd39);
    send_word(pts_pkg::OpCreate, '0, '0);
    send_word(pts_pkg::OpGetPrio, 6'd1, '0);
    send_word(pts_pkg::OpSetPrio, 6'd2, -8'sd1);     // new priority must not strand the queued task
    send_word(pts_pkg::OpGetPrio, 6'd2, '0);
    send_word(pts_pkg::OpGetPrio, '0, '0);           // id zero
    send_word(pts_pkg::OpGetPrio, 6'd63, '0);        // unused slot
    send_word(3'd5, 6'h2a, 8'sh55);
    send_word(3'd7, 6'h15, -8'sh56);
    send_word(3'd6, '0, '0);
    send_word(pts_pkg::OpSchedule, '0, '0);
    send_word(pts_pkg::OpTerminate, 6'd4, '0);       // task already scheduled, so not queued
    send_word(pts_pkg::OpTerminate, 6'd4, '0);
    send_word(pts_pkg::OpSchedule, '0, '0);
    send_word(pts_pkg::OpTerminate, 6'd1, '0);       // current task terminated
    send_word(pts_pkg::OpSchedule, '0, '0);
    send_word(pts_pkg::OpSchedule, '0, '0);
    send_word(pts_pkg::OpTerminate, 6'd2, '0);
    send_word(pts_pkg::OpTerminate, 6'd3, '0);
    drain();
  endtask

  // Fill the table, the receiver held off at the start, then overflow it
  task automatic test_table_full;
    long_hold = 1'b1;
    for (int i = 0; i < 66; i++)
      send_word(pts_pkg::OpCreate, '0, 8'($urandom_range(0, 255)));
    drain();
    for (int i = 0; i < 30; i++) send_word(pts_pkg::OpSchedule, '0, '0);
    for (int i = 1; i < pts_pkg::MaxTasks; i++) send_word(pts_pkg::OpTerminate, 6'(i), '0);
    drain();
  endtask

  task automatic test_random(int n);
    int m;
    logic [5:0] id;
    for (int i = 0; i < n; i++) begin
      m = $urandom_range(0, 99);
      id = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : live_or_any();
      if (m < 30) send_word(pts_pkg::OpCreate, 6'($urandom_range(0, 63)),
                            ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 45)));
      else if (m < 50) send_word(pts_pkg::OpSchedule, 6'($urandom_range(0, 63)), 8'($urandom));
      else if (m < 70) send_word(pts_pkg::OpTerminate, id, 8'($urandom));
      else if (m < 82) send_word(pts_pkg::OpSetPrio, id, 8'($urandom));
      else if (m < 96) send_word(pts_pkg::OpGetPrio, id, 8'($urandom));
      else send_word(3'($urandom_range(5, 7)), 6'($urandom), 8'($urandom));
      if (i % 700 == 350) drain();
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < pts_pkg::MaxTasks; i++) begin
      t_used[i] = 1'b0; t_queued[i] = 1'b0; t_prio[i] = '0; t_level[i] = 0; t_next[i] = 0;
    end
    for (int i = 0; i < pts_pkg::NumLevels; i++) head[i] = 0;
    for (int i = 0; i < 8; i++) op_hits[i] = 0;
    current_id = 0;
    switch_total = '0;
    occupied = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_table_full();
    test_random(1850);
    repeat (200) @(negedge clk);
    done = 1'b1;
    $display("sent %0d words, checked %0d results: create %0d, schedule %0d, terminate %0d",
             words_sent, words_seen, op_hits[0], op_hits[1], op_hits[2]);
    $display("set %0d, get %0d, unknown modes %0d, switches %0d",
             op_hits[3], op_hits[4], op_hits[5] + op_hits[6] + op_hits[7], switch_total);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/pts_pkg.sv
src/priority_task_scheduler_unit.sv
verif/tb_top.sv
